FILE: hw/rtl/dgp_pkg.sv
// dgp_pkg: shared types and constants for the delaunay geometric predicates block
// payload structs, difference item, back-end status and sign codes; no dependencies

package dgp_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int LIFT_W     = PROD_W + 1;
  localparam int SPLIT_W    = (LIFT_W + 1) / 2;
  localparam int HI_W       = LIFT_W - SPLIT_W;
  localparam int PP_W       = 2 * SPLIT_W + 2;
  localparam int DET_W      = 2 * LIFT_W + 2;

  localparam int BACK_LAT   = 6;
  localparam int OUT_DEPTH  = BACK_LAT + 2;
  localparam int MID_DEPTH  = 4;
  localparam int INFL_W     = $clog2(BACK_LAT + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [1:0]            sgn_t;

  localparam sgn_t SIGN_ZERO = 2'sb00;
  localparam sgn_t SIGN_POS  = 2'sb01;
  localparam sgn_t SIGN_NEG  = 2'sb11;

  typedef enum logic {
    OP_ORIENT   = 1'b0,
    OP_INCIRCLE = 1'b1
  } op_t;

  typedef struct packed {
    logic   mode;
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
    coord_t d_x;
    coord_t d_y;
  } in_t;

  typedef struct packed {
    sgn_t sign_result;
    logic degenerate;
  } out_t;

  typedef struct packed {
    op_t   op;
    diff_t acx;
    diff_t acy;
    diff_t bcx;
    diff_t bcy;
    diff_t adx;
    diff_t ady;
    diff_t bdx;
    diff_t bdy;
    diff_t cdx;
    diff_t cdy;
  } diff_item_t;

  typedef struct packed {
    logic              res_valid;
    logic [INFL_W-1:0] inflight;
  } back_stat_t;

endpackage

FILE: hw/rtl/dgp_fifo.sv
// dgp_fifo: small synchronous queue of any packed item type
// used between front and back and as the result queue; no package dependency

module dgp_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4,
  localparam int AW     = $clog2(DEPTH),
  localparam int CW     = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  item_t         wdata,
  input  logic          pop,
  output item_t         rdata,
  output logic          full,
  output logic          empty,
  output logic [CW-1:0] count
);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/dgp_front.sv
// dgp_front: input stage, classifies the transfer and forms coordinate differences
// depends on dgp_pkg

module dgp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dgp_pkg::in_t        in_data,
  output logic                full,
  input  logic                mid_full,
  output logic                mid_push,
  output dgp_pkg::diff_item_t mid_data
);

  logic                front_v_r, front_v_nxt;
  dgp_pkg::diff_item_t front_r, front_nxt;
  logic                advance;

  assign advance  = !front_v_r || !mid_full;
  assign full     = !advance;
  assign mid_push = front_v_r && !mid_full;
  assign mid_data = front_r;

  always_comb begin
    front_v_nxt   = advance ? push : front_v_r;
    front_nxt.op  = in_data.mode ? dgp_pkg::OP_INCIRCLE : dgp_pkg::OP_ORIENT;
    front_nxt.acx = dgp_pkg::diff_t'(in_data.a_x) - dgp_pkg::diff_t'(in_data.c_x);
    front_nxt.acy = dgp_pkg::diff_t'(in_data.a_y) - dgp_pkg::diff_t'(in_data.c_y);
    front_nxt.bcx = dgp_pkg::diff_t'(in_data.b_x) - dgp_pkg::diff_t'(in_data.c_x);
    front_nxt.bcy = dgp_pkg::diff_t'(in_data.b_y) - dgp_pkg::diff_t'(in_data.c_y);
    front_nxt.adx = dgp_pkg::diff_t'(in_data.a_x) - dgp_pkg::diff_t'(in_data.d_x);
    front_nxt.ady = dgp_pkg::diff_t'(in_data.a_y) - dgp_pkg::diff_t'(in_data.d_y);
    front_nxt.bdx = dgp_pkg::diff_t'(in_data.b_x) - dgp_pkg::diff_t'(in_data.d_x);
    front_nxt.bdy = dgp_pkg::diff_t'(in_data.b_y) - dgp_pkg::diff_t'(in_data.d_y);
    front_nxt.cdx = dgp_pkg::diff_t'(in_data.c_x) - dgp_pkg::diff_t'(in_data.d_x);
    front_nxt.cdy = dgp_pkg::diff_t'(in_data.c_y) - dgp_pkg::diff_t'(in_data.d_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      front_r <= front_nxt;
    end
  end

endmodule

FILE: hw/rtl/dgp_back.sv
// dgp_back: six-stage exact arithmetic pipeline for orientation and incircle signs
// depends on dgp_pkg; wide products are split into half-width partial products

module dgp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                issue,
  input  dgp_pkg::diff_item_t item,
  output dgp_pkg::out_t       res,
  output dgp_pkg::back_stat_t stat
);

  localparam int LAT = dgp_pkg::BACK_LAT;
  localparam int S   = dgp_pkg::SPLIT_W;

  typedef logic signed [dgp_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [dgp_pkg::LIFT_W-1:0] wide_t;
  typedef logic signed [dgp_pkg::PP_W-1:0]   pp_t;
  typedef logic signed [dgp_pkg::DET_W-1:0]  det_t;

  function automatic prod_t mul(dgp_pkg::diff_t a, dgp_pkg::diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic dgp_pkg::sgn_t neg_sign(dgp_pkg::sgn_t s);
    dgp_pkg::sgn_t r;
    case (s)
      dgp_pkg::SIGN_POS: r = dgp_pkg::SIGN_NEG;
      dgp_pkg::SIGN_NEG: r = dgp_pkg::SIGN_POS;
      default:           r = dgp_pkg::SIGN_ZERO;
    endcase
    return r;
  endfunction

  logic [LAT-1:0] v_r, v_nxt;

  // stage 1: products of differences
  dgp_pkg::op_t op1_r;
  prod_t        or1_r [2];
  prod_t        sq1_r [6];
  prod_t        cr1_r [6];
  prod_t        or1_nxt [2];
  prod_t        sq1_nxt [6];
  prod_t        cr1_nxt [6];

  // stage 2: orientation sign, lifts, cofactors
  dgp_pkg::op_t  op2_r;
  dgp_pkg::sgn_t os2_r, os2_nxt;
  wide_t         lift2_r [3];
  wide_t         cof2_r [3];
  wide_t         lift2_nxt [3];
  wide_t         cof2_nxt [3];
  wide_t         od;

  // stage 3: partial products
  dgp_pkg::op_t  op3_r;
  dgp_pkg::sgn_t os3_r;
  pp_t           ll3_r [3];
  pp_t           lh3_r [3];
  pp_t           hl3_r [3];
  pp_t           hh3_r [3];
  pp_t           ll3_nxt [3];
  pp_t           lh3_nxt [3];
  pp_t           hl3_nxt [3];
  pp_t           hh3_nxt [3];

  // stage 4: full terms
  dgp_pkg::op_t  op4_r;
  dgp_pkg::sgn_t os4_r;
  det_t          term4_r [3];
  det_t          term4_nxt [3];

  // stage 5: determinant
  dgp_pkg::op_t  op5_r;
  dgp_pkg::sgn_t os5_r;
  det_t          det5_r, det5_nxt;

  // stage 6: result
  dgp_pkg::out_t res6_r, res6_nxt;
  dgp_pkg::sgn_t ds;

  assign v_nxt          = {v_r[LAT-2:0], issue};
  assign res            = res6_r;
  assign stat.res_valid = v_r[LAT-1];
  assign stat.inflight  = dgp_pkg::INFL_W'($countones(v_r));

  always_comb begin
    or1_nxt[0] = mul(item.acx, item.bcy);
    or1_nxt[1] = mul(item.acy, item.bcx);
    sq1_nxt[0] = mul(item.adx, item.adx);
    sq1_nxt[1] = mul(item.ady, item.ady);
    sq1_nxt[2] = mul(item.bdx, item.bdx);
    sq1_nxt[3] = mul(item.bdy, item.bdy);
    sq1_nxt[4] = mul(item.cdx, item.cdx);
    sq1_nxt[5] = mul(item.cdy, item.cdy);
    cr1_nxt[0] = mul(item.bdx, item.cdy);
    cr1_nxt[1] = mul(item.cdx, item.bdy);
    cr1_nxt[2] = mul(item.cdx, item.ady);
    cr1_nxt[3] = mul(item.adx, item.cdy);
    cr1_nxt[4] = mul(item.adx, item.bdy);
    cr1_nxt[5] = mul(item.bdx, item.ady);
  end

  always_comb begin
    od = wide_t'(or1_r[0]) - wide_t'(or1_r[1]);
    if (od[dgp_pkg::LIFT_W-1]) begin
      os2_nxt = dgp_pkg::SIGN_NEG;
    end else if (|od) begin
      os2_nxt = dgp_pkg::SIGN_POS;
    end else begin
      os2_nxt = dgp_pkg::SIGN_ZERO;
    end
    for (int i = 0; i < 3; i++) begin
      lift2_nxt[i] = wide_t'(sq1_r[2*i]) + wide_t'(sq1_r[2*i+1]);
      cof2_nxt[i]  = wide_t'(cr1_r[2*i]) - wide_t'(cr1_r[2*i+1]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ll3_nxt[i] = pp_t'({1'b0, lift2_r[i][S-1:0]}) * pp_t'({1'b0, cof2_r[i][S-1:0]});
      lh3_nxt[i] = pp_t'({1'b0, lift2_r[i][S-1:0]})
                 * pp_t'($signed(cof2_r[i][dgp_pkg::LIFT_W-1:S]));
      hl3_nxt[i] = pp_t'($signed(lift2_r[i][dgp_pkg::LIFT_W-1:S]))
                 * pp_t'({1'b0, cof2_r[i][S-1:0]});
      hh3_nxt[i] = pp_t'($signed(lift2_r[i][dgp_pkg::LIFT_W-1:S]))
                 * pp_t'($signed(cof2_r[i][dgp_pkg::LIFT_W-1:S]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term4_nxt[i] = det_t'(ll3_r[i])
                   + ((det_t'(lh3_r[i]) + det_t'(hl3_r[i])) <<< S)
                   + (det_t'(hh3_r[i]) <<< (2 * S));
    end
    det5_nxt = term4_r[0] + term4_r[1] + term4_r[2];
  end

  always_comb begin
    if (det5_r[dgp_pkg::DET_W-1]) begin
      ds = dgp_pkg::SIGN_NEG;
    end else if (|det5_r) begin
      ds = dgp_pkg::SIGN_POS;
    end else begin
      ds = dgp_pkg::SIGN_ZERO;
    end
    res6_nxt.degenerate  = 1'b0;
    res6_nxt.sign_result = os5_r;
    if (op5_r == dgp_pkg::OP_INCIRCLE) begin
      if (os5_r == dgp_pkg::SIGN_ZERO) begin
        res6_nxt.degenerate  = 1'b1;
        res6_nxt.sign_result = dgp_pkg::SIGN_ZERO;
      end else if (os5_r == dgp_pkg::SIGN_NEG) begin
        res6_nxt.sign_result = neg_sign(ds);
      end else begin
        res6_nxt.sign_result = ds;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op1_r   <= item.op;
    or1_r   <= or1_nxt;
    sq1_r   <= sq1_nxt;
    cr1_r   <= cr1_nxt;
    op2_r   <= op1_r;
    os2_r   <= os2_nxt;
    lift2_r <= lift2_nxt;
    cof2_r  <= cof2_nxt;
    op3_r   <= op2_r;
    os3_r   <= os2_r;
    ll3_r   <= ll3_nxt;
    lh3_r   <= lh3_nxt;
    hl3_r   <= hl3_nxt;
    hh3_r   <= hh3_nxt;
    op4_r   <= op3_r;
    os4_r   <= os3_r;
    term4_r <= term4_nxt;
    op5_r   <= op4_r;
    os5_r   <= os4_r;
    det5_r  <= det5_nxt;
    res6_r  <= res6_nxt;
  end

endmodule

FILE: hw/rtl/delaunay_geometric_predicates.sv
// delaunay_geometric_predicates: top level, front stage, decoupling queue, pipeline, result queue
// depends on dgp_pkg, dgp_front, dgp_fifo and dgp_back
//
// Exact orientation (mode 0) and incircle (mode 1) sign of signed fixed-point points; the
// fraction point scales all coordinates alike and does not enter the logic. One item is taken
// per cycle and one result delivered per cycle sustained while the consumer keeps popping. An
// item passes the difference stage, the decoupling queue, the arithmetic pipeline (products,
// lifts and cofactors, split partial products, term assembly, determinant sum, sign) and the
// result queue, in that order. The pipeline only issues when the result
// queue has room for every item in flight, so a stalled consumer backs up into the decoupling
// queue and then into full without losing a transfer.

module delaunay_geometric_predicates #(
  parameter int QUEUE_DEPTH = dgp_pkg::MID_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  dgp_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output dgp_pkg::out_t out_data
);

  localparam int OUT_CW = $clog2(dgp_pkg::OUT_DEPTH + 1);

  logic                mid_push, mid_full, mid_empty, issue, room;
  dgp_pkg::diff_item_t mid_wdata, mid_rdata;
  dgp_pkg::out_t       back_res;
  dgp_pkg::back_stat_t back_stat;
  logic [OUT_CW-1:0]   out_count;

  assign room  = ((OUT_CW + 1)'(out_count) + (OUT_CW + 1)'(back_stat.inflight))
                 < (OUT_CW + 1)'(dgp_pkg::OUT_DEPTH);
  assign issue = !mid_empty && room;

  dgp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  dgp_fifo #(
    .item_t (dgp_pkg::diff_item_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (issue),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty),
    .count ()
  );

  dgp_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .item  (mid_rdata),
    .res   (back_res),
    .stat  (back_stat)
  );

  dgp_fifo #(
    .item_t (dgp_pkg::out_t),
    .DEPTH  (dgp_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_stat.res_valid),
    .wdata (back_res),
    .pop   (pop),
    .rdata (out_data),
    .full  (),
    .empty (empty),
    .count (out_count)
  );

endmodule

FILE: hw/rtl/dgp_checker.sv
// dgp_checker: port-level checks for delaunay_geometric_predicates, bound to the top level
// depends on dgp_pkg

module dgp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input dgp_pkg::out_t out_data
);

  logic [7:0] pend_r, pend_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_comb begin
    pend_nxt = pend_r + {7'd0, in_xfer} - {7'd0, out_xfer};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not idle after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> pend_r != 8'd0)
    else $error("result shown with no transfer outstanding");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("waiting result changed or vanished");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.degenerate |-> out_data.sign_result == dgp_pkg::SIGN_ZERO)
    else $error("degenerate result with nonzero sign");

endmodule

bind delaunay_geometric_predicates dgp_checker u_dgp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
